@@ hdl/spmf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared types and constants for the strict priority four-class queue.
// ----------------------------------------------------------------------------
package spmf_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int DATA_W      = 32;
    localparam int CCOUNT_W    = 5;
    localparam int TCOUNT_W    = 7;

    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DROP  = 2'd2
    } status_t;

    // one request as seen by the queue control
    typedef struct packed
    {
        cmd_t             cmd;
        logic [CLS_W-1:0] cls;
    } op_t;

    // response fields produced by the queue control
    typedef struct packed
    {
        status_t             status;
        logic                deq_hit;
        logic [CCOUNT_W-1:0] class_count;
        logic [TCOUNT_W-1:0] total_count;
    } res_t;

endpackage
`default_nettype wire

@@ hdl/spmf_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spmf_in_if
// Request channel: command, class and payload with valid/ready.
// ----------------------------------------------------------------------------
interface spmf_in_if
    import spmf_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              command;
    logic [CLS_W-1:0]  priority_class;
    logic [DATA_W-1:0] payload;

    modport source
    (
        output valid,
        output command,
        output priority_class,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  command,
        input  priority_class,
        input  payload,
        output ready
    );

endinterface
`default_nettype wire

@@ hdl/spmf_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spmf_out_if
// Response channel: status, popped word and occupancy with valid/ready.
// ----------------------------------------------------------------------------
interface spmf_out_if
    import spmf_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [DATA_W-1:0]   data_out;
    logic [CCOUNT_W-1:0] class_count;
    logic [TCOUNT_W-1:0] total_count;

    modport source
    (
        output valid,
        output status,
        output data_out,
        output class_count,
        output total_count,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  status,
        input  data_out,
        input  class_count,
        input  total_count,
        output ready
    );

endinterface
`default_nettype wire

@@ hdl/spmf_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spmf_store
// Entry memory for all classes: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spmf_store
    import spmf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                            clk,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(4*DEPTH)-1:0]      wr_addr,
    input  wire logic [DATA_W-1:0]               wr_data,
    input  wire logic                            rd_en,
    input  wire logic [$clog2(4*DEPTH)-1:0]      rd_addr,
    output logic      [DATA_W-1:0]               rd_data
);

    localparam int ENTRIES = NUM_CLASSES * DEPTH;

    logic [DATA_W-1:0] mem [ENTRIES];
    logic [DATA_W-1:0] rd_data_reg;

    // hold read data while the response stage is stalled
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ hdl/spmf_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spmf_ctrl
// Per-class pointers and occupancy, strict priority pick, status and counts.
// ----------------------------------------------------------------------------
module spmf_ctrl
    import spmf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            op_valid,
    input  wire op_t                             op,
    output logic                                 wr_en,
    output logic      [$clog2(4*DEPTH)-1:0]      wr_addr,
    output logic                                 rd_en,
    output logic      [$clog2(4*DEPTH)-1:0]      rd_addr,
    output res_t                                 res
);

    localparam int AW  = $clog2(DEPTH);
    localparam int MAW = $clog2(NUM_CLASSES * DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int TW  = $clog2(NUM_CLASSES * DEPTH + 1);

    logic [AW-1:0] head_reg [NUM_CLASSES];
    logic [AW-1:0] tail_reg [NUM_CLASSES];
    logic [CW-1:0] occ_reg  [NUM_CLASSES];
    logic [TW-1:0] total_reg;

    logic [AW-1:0] head_next [NUM_CLASSES];
    logic [AW-1:0] tail_next [NUM_CLASSES];
    logic [CW-1:0] occ_next  [NUM_CLASSES];
    logic [TW-1:0] total_next;

    logic             full;
    logic             any;
    logic [CLS_W-1:0] sel;
    logic             enq_ok;
    logic             deq_ok;

    logic [CW+CCOUNT_W-1:0] class_ext;
    logic [TW+TCOUNT_W-1:0] total_ext;

    // pick the highest-priority non-empty class
    always_comb
    begin
        any = 1'b0;
        sel = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (occ_reg[i] != '0)
            begin
                any = 1'b1;
                sel = CLS_W'(i);
            end
        end
    end

    assign full   = (occ_reg[op.cls] == CW'(DEPTH));
    assign enq_ok = (op.cmd == CMD_ENQ) && !full;
    assign deq_ok = (op.cmd == CMD_DEQ) && any;

    assign wr_en   = op_valid && enq_ok;
    assign rd_en   = op_valid && deq_ok;
    assign wr_addr = MAW'(op.cls) * MAW'(DEPTH) + MAW'(tail_reg[op.cls]);
    assign rd_addr = MAW'(sel) * MAW'(DEPTH) + MAW'(head_reg[sel]);

    always_comb
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            occ_next[i]  = occ_reg[i];
            if (enq_ok && (op.cls == CLS_W'(i)))
            begin
                tail_next[i] = (tail_reg[i] == AW'(DEPTH - 1)) ? '0 : tail_reg[i] + 1'b1;
                occ_next[i]  = occ_reg[i] + 1'b1;
            end
            if (deq_ok && (sel == CLS_W'(i)))
            begin
                head_next[i] = (head_reg[i] == AW'(DEPTH - 1)) ? '0 : head_reg[i] + 1'b1;
                occ_next[i]  = occ_reg[i] - 1'b1;
            end
        end
        total_next = total_reg + TW'(enq_ok) - TW'(deq_ok);
    end

    // counts are reported modulo their field widths
    assign class_ext = (CW + CCOUNT_W)'(occ_next[op.cls]);
    assign total_ext = (TW + TCOUNT_W)'(total_next);

    always_comb
    begin
        if ((op.cmd == CMD_ENQ) && full)
        begin
            res.status = ST_DROP;
        end
        else if ((op.cmd == CMD_DEQ) && !any)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            res.status = ST_OK;
        end
        res.deq_hit     = deq_ok;
        res.class_count = class_ext[CCOUNT_W-1:0];
        res.total_count = total_ext[TCOUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
            total_reg <= '0;
        end
        else if (op_valid)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                occ_reg[i]  <= occ_next[i];
            end
            total_reg <= total_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/strict_priority_multi_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// Four-class strict priority queue with one response per request.
// ----------------------------------------------------------------------------
// Each request is either an enqueue, which appends the payload word to the
// FIFO of its priority class, or a dequeue, which pops the oldest word of
// the highest-priority class (0 highest, 3 lowest) that holds anything.
// Each class holds DEPTH words; an enqueue to a full class is dropped with
// status 2, and a dequeue with every class empty returns status 1. Every
// response carries the popped word (zero unless a dequeue succeeded), the
// occupancy of the class named in the request and the total occupancy, both
// taken after the request. Throughput is one request per clock while the
// responses are taken. The request register feeds the decision stage, and
// its result register and the registered read port of the memory form the
// response. While a response waits, one more request is taken into the
// request register.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo
    import spmf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    spmf_in_if.sink      in_ch,
    spmf_out_if.source   out_ch
);

    localparam int MAW = $clog2(NUM_CLASSES * DEPTH);

    // request register
    logic              in_valid_reg;
    op_t               op_reg;
    logic [DATA_W-1:0] payload_reg;

    // response register
    logic              out_valid_reg;
    res_t              res_reg;

    logic              out_free;
    logic              s1_adv;
    logic              in_fire;

    logic              wr_en;
    logic              rd_en;
    logic [MAW-1:0]    wr_addr;
    logic [MAW-1:0]    rd_addr;
    logic [DATA_W-1:0] rd_data;
    res_t              res;

    // advance the decision stage whenever a request is held and the response slot is free
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_adv      = in_valid_reg && out_free;
    assign in_ch.ready = !in_valid_reg || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    // capture the request payload on acceptance
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg.cmd  <= cmd_t'(in_ch.command);
            op_reg.cls  <= in_ch.priority_class;
            payload_reg <= in_ch.payload;
        end
    end

    spmf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (s1_adv),
        .op       (op_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .res      (res)
    );

    // the read data register of the store is the data field of the response
    spmf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (payload_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // hold the response until it is taken, drop valid once it is
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = res_reg.status;
    assign out_ch.data_out    = res_reg.deq_hit ? rd_data : '0;
    assign out_ch.class_count = res_reg.class_count;
    assign out_ch.total_count = res_reg.total_count;

endmodule
`default_nettype wire

@@ tb/sv/strict_priority_multi_fifo_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo_tb
// Self-checking bench for the four-class strict priority queue.
// ----------------------------------------------------------------------------
// The bench drives enqueue and dequeue requests into the request channel and
// takes responses from the response channel. Both sides insert random gaps,
// with some stretches that have no gaps at all. A small checker keeps one
// word queue per priority class. It predicts every response when a request
// is accepted, and it compares each response field by field with the oldest
// prediction. A short directed opening covers these cases:
//   - a dequeue on an empty queue
//   - the extreme payload words
//   - filling a class until an enqueue is dropped
//   - the strict order of service between the classes
// Random bursts follow. Each burst has its own enqueue/dequeue mix, and some
// bursts aim at a single class, so that full and empty classes occur often.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_tb;

    import spmf_pkg::*;

    localparam int QUEUE_DEPTH     = 16;
    localparam int RANDOM_REQUESTS = 1250;
    localparam int MAX_GAP         = 16;
    localparam int STALL_LIMIT     = 400;   // cycles with no handshake on either side
    localparam int DRAIN_CYCLES    = 10;

    // ------------------------------------------------------------------------
    // Checker: per-class word queues and the responses they predict
    // ------------------------------------------------------------------------
    class class_queue_checker;

        typedef struct
        {
            status_t             status;
            logic [DATA_W-1:0]   data_out;
            logic [CCOUNT_W-1:0] class_count;
            logic [TCOUNT_W-1:0] total_count;
        } response_s;

        int                depth;
        int                errors;
        logic [DATA_W-1:0] class_words[NUM_CLASSES][$];
        response_s         expected_responses[$];

        function new(int depth_i);
            depth  = depth_i;
            errors = 0;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // Advance the class queues by one accepted request and hold its response.
        function void note_request(cmd_t cmd, logic [CLS_W-1:0] cls, logic [DATA_W-1:0] word);
            response_s r;
            int        total;
            r.status   = ST_OK;
            r.data_out = '0;
            if (cmd == CMD_ENQ)
            begin
                if (class_words[cls].size() >= depth)
                    r.status = ST_DROP;
                else
                    class_words[cls].insert(class_words[cls].size(), word);
            end
            else
            begin
                r.status = ST_EMPTY;
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    if (r.status == ST_EMPTY && class_words[c].size() != 0)
                    begin
                        r.data_out = class_words[c].pop_front();
                        r.status   = ST_OK;
                    end
                end
            end
            total = 0;
            for (int c = 0; c < NUM_CLASSES; c++)
                total += class_words[c].size();
            r.class_count = CCOUNT_W'(class_words[cls].size());
            r.total_count = TCOUNT_W'(total);
            expected_responses.insert(expected_responses.size(), r);
        endfunction

        function void check_response(logic [1:0] status, logic [DATA_W-1:0] data_out,
                                     logic [CCOUNT_W-1:0] class_count,
                                     logic [TCOUNT_W-1:0] total_count);
            response_s exp;
            if (expected_responses.size() == 0)
            begin
                $display("%0t: response with none expected: status %0d data %h", $time,
                         status, data_out);
                errors++;
                return;
            end
            exp = expected_responses.pop_front();
            if (status !== exp.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
                errors++;
            end
            if (data_out !== exp.data_out)
            begin
                $display("%0t: data_out expected %h actual %h", $time, exp.data_out, data_out);
                errors++;
            end
            if (class_count !== exp.class_count)
            begin
                $display("%0t: class_count expected %0d actual %0d", $time, exp.class_count,
                         class_count);
                errors++;
            end
            if (total_count !== exp.total_count)
            begin
                $display("%0t: total_count expected %0d actual %0d", $time, exp.total_count,
                         total_count);
                errors++;
            end
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block under test
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    spmf_in_if  in_ch ();
    spmf_out_if out_ch ();

    strict_priority_multi_fifo #(.DEPTH(QUEUE_DEPTH)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    class_queue_checker queue_check;

    int send_calm;   // requests left in a gap-free stretch on the request side
    int recv_calm;   // responses left in a gap-free stretch on the response side

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Draw the idle cycles before the next handshake. Now and then open a
    // stretch with no idling so that back-to-back traffic is exercised too.
    function automatic int pick_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(10, 60);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Present one request and hold it until the block takes it. Keep valid
    // high between back-to-back requests; drop it only for a real gap.
    task automatic send_request(cmd_t cmd, logic [CLS_W-1:0] cls, logic [DATA_W-1:0] word);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.command        <= cmd;
        in_ch.priority_class <= cls;
        in_ch.payload        <= word;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: note accepted requests, check accepted responses. The values
    // are sampled before this edge's updates land, so the order of processes
    // does not matter.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            queue_check.note_request(cmd_t'(in_ch.command), in_ch.priority_class,
                                     in_ch.payload);
        if (rst_n && out_ch.valid && out_ch.ready)
            queue_check.check_response(out_ch.status, out_ch.data_out, out_ch.class_count,
                                       out_ch.total_count);
    end

    // ------------------------------------------------------------------------
    // Response side: stall ready at random, then hold it until a response
    // has been taken.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        recv_calm    = 0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            gap = pick_gap(recv_calm);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when neither channel moves for too long.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int               sent;
        int               burst_len;
        int               enq_pct;
        bit               focused;
        logic [CLS_W-1:0] focus_cls;
        logic [CLS_W-1:0] cls;
        cmd_t             cmd;

        queue_check = new(QUEUE_DEPTH);
        send_calm   = 0;

        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.command        <= CMD_ENQ;
        in_ch.priority_class <= '0;
        in_ch.payload        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening.
        // Dequeue with every class empty.
        send_request(CMD_DEQ, CLS_W'($urandom_range(0, 3)), $urandom);
        // Extreme and mixed payload words in the three upper classes.
        send_request(CMD_ENQ, 2'd0, 32'h0000_0000);
        send_request(CMD_ENQ, 2'd1, 32'hFFFF_FFFF);
        send_request(CMD_ENQ, 2'd2, 32'hA5A5_5A5A);
        // Fill the lowest class, then push once more so the enqueue is dropped.
        repeat (QUEUE_DEPTH + 1)
            send_request(CMD_ENQ, 2'd3, $urandom);
        // Drain one word per class; the service order must follow priority.
        repeat (NUM_CLASSES)
            send_request(CMD_DEQ, CLS_W'($urandom_range(0, 3)), $urandom);

        // Random bursts. Each burst picks its own enqueue share, so the queue
        // swings between full classes and an empty queue. Some bursts aim at
        // a single class to push it into drops.
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            enq_pct   = $urandom_range(1, 9) * 10;
            focused   = ($urandom_range(0, 3) == 0);
            focus_cls = CLS_W'($urandom_range(0, 3));
            burst_len = $urandom_range(20, 100);
            for (int i = 0; i < burst_len && sent < RANDOM_REQUESTS; i++)
            begin
                cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                cls = focused ? focus_cls : CLS_W'($urandom_range(0, 3));
                send_request(cmd, cls, $urandom);
                sent++;
            end
        end
        in_ch.valid <= 1'b0;

        // Let the monitor note the last request, wait for every predicted
        // response, then watch a little longer for any stray response.
        @(posedge clk);
        while (queue_check.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (queue_check.errors == 0 && queue_check.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
